>>> rtl/wsdf_pkg.sv
package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_SKIP = 3'd4,
        PH_DATA = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_CLOSE = 2'd2,
        KIND_PING  = 2'd3
    } t_kind;

    localparam logic [3:0]  OP_TEXT      = 4'h1;
    localparam logic [3:0]  OP_CLOSE     = 4'h8;
    localparam logic [3:0]  OP_PING      = 4'h9;
    localparam logic [6:0]  LEN_EXT16    = 7'd126;
    localparam logic [6:0]  LEN_EXT64    = 7'd127;
    localparam logic [2:0]  EXT16_BYTES  = 3'd1;
    localparam logic [2:0]  EXT64_BYTES  = 3'd7;
    localparam logic [15:0] LIMIT_RESET  = 16'd4096;

endpackage

>>> rtl/websocket_frame_deframer.sv
// A byte accepted on s_axis passes the input register, then the result register,
// before any result it gives shows on m_axis.
// Throughput: one byte per cycle; s_axis_tready drops only while m_axis is stalled
// and both registers are full.
// Reset (i_rst_n low, synchronous): parser returns to the first header byte,
// both registers empty, payload limit back to 4096.
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,      // payload_limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // [7:0] data_byte
    output logic [3:0]  m_axis_tuser,     // [1:0] kind, [2] is_text, [3] truncated
    output logic        m_axis_tlast
);

    logic [15:0]       r_limit;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    logic [7:0]        r_out_data;
    wsdf_pkg::t_kind   r_out_kind;
    logic              r_out_text;
    logic              r_out_last;
    logic              r_out_trunc;

    wsdf_pkg::t_phase  r_phase,     n_phase;
    logic [3:0]        r_opcode,    n_opcode;
    logic              r_mask_on,   n_mask_on;
    logic [63:0]       r_rem,       n_rem;
    logic [2:0]        r_ext_cnt,   n_ext_cnt;
    logic [31:0]       r_key,       n_key;
    logic [1:0]        r_key_idx,   n_key_idx;
    logic [15:0]       r_delivered, n_delivered;

    logic              advance;
    logic              step;
    logic              len_go;
    logic              hd_go;
    logic [63:0]       len_val;
    logic              len_mask;
    logic              res_valid;
    wsdf_pkg::t_kind   res_kind;
    logic [7:0]        res_data;
    logic              res_text;
    logic              res_last;
    logic              res_trunc;
    logic [7:0]        key_byte;
    logic              rem_one;
    logic              at_limit;
    logic              is_ctrl;

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign rem_one  = (r_rem == 64'd1);
    assign at_limit = ((r_delivered + 16'd1) == r_limit);
    assign is_ctrl  = (r_opcode == wsdf_pkg::OP_CLOSE) || (r_opcode == wsdf_pkg::OP_PING);

    always_comb begin
        case (r_key_idx)
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_mask_on   = r_mask_on;
        n_rem       = r_rem;
        n_ext_cnt   = r_ext_cnt;
        n_key       = r_key;
        n_key_idx   = r_key_idx;
        n_delivered = r_delivered;
        len_go      = 1'b0;
        hd_go       = 1'b0;
        len_val     = r_rem;
        len_mask    = r_mask_on;
        res_valid   = 1'b0;
        res_kind    = wsdf_pkg::KIND_DATA;
        res_data    = 8'd0;
        res_text    = 1'b0;
        res_last    = 1'b0;
        res_trunc   = 1'b0;

        case (r_phase)
            wsdf_pkg::PH_HDR1: begin
                n_mask_on = r_in_byte[7];
                n_key     = 32'd0;
                n_rem     = 64'd0;
                if (r_in_byte[6:0] == wsdf_pkg::LEN_EXT16
                        || r_in_byte[6:0] == wsdf_pkg::LEN_EXT64) begin
                    n_ext_cnt = (r_in_byte[6:0] == wsdf_pkg::LEN_EXT16)
                              ? wsdf_pkg::EXT16_BYTES : wsdf_pkg::EXT64_BYTES;
                    n_phase   = wsdf_pkg::PH_EXT;
                end else begin
                    n_rem    = {57'd0, r_in_byte[6:0]};
                    len_go   = 1'b1;
                    len_val  = {57'd0, r_in_byte[6:0]};
                    len_mask = r_in_byte[7];
                end
            end
            wsdf_pkg::PH_EXT: begin
                n_rem = {r_rem[55:0], r_in_byte};
                if (r_ext_cnt == 3'd0) begin
                    len_go  = 1'b1;
                    len_val = {r_rem[55:0], r_in_byte};
                end else begin
                    n_ext_cnt = r_ext_cnt - 3'd1;
                end
            end
            wsdf_pkg::PH_KEY: begin
                n_key = {r_key[23:0], r_in_byte};
                if (r_key_idx == 2'd3) begin
                    n_key_idx = 2'd0;
                    hd_go     = 1'b1;
                end else begin
                    n_key_idx = r_key_idx + 2'd1;
                end
            end
            wsdf_pkg::PH_SKIP: begin
                n_rem = r_rem - 64'd1;
                if (rem_one)
                    n_phase = wsdf_pkg::PH_HDR0;
            end
            wsdf_pkg::PH_DATA: begin
                n_key_idx = r_key_idx + 2'd1;
                n_rem     = r_rem - 64'd1;
                if (rem_one)
                    n_phase = wsdf_pkg::PH_HDR0;
                if (r_delivered < r_limit) begin
                    res_valid   = 1'b1;
                    res_data    = r_in_byte ^ key_byte;
                    res_text    = (r_opcode == wsdf_pkg::OP_TEXT);
                    res_last    = rem_one || at_limit;
                    res_trunc   = at_limit && !rem_one;
                    n_delivered = r_delivered + 16'd1;
                end
            end
            default: begin
                n_opcode = r_in_byte[3:0];
                n_phase  = wsdf_pkg::PH_HDR1;
            end
        endcase

        if (len_go) begin
            if (len_mask) begin
                n_phase   = wsdf_pkg::PH_KEY;
                n_key_idx = 2'd0;
            end else begin
                hd_go = 1'b1;
            end
        end

        if (hd_go) begin
            if (is_ctrl) begin
                n_phase   = (len_val != 64'd0) ? wsdf_pkg::PH_SKIP : wsdf_pkg::PH_HDR0;
                res_valid = 1'b1;
                res_kind  = (r_opcode == wsdf_pkg::OP_CLOSE)
                          ? wsdf_pkg::KIND_CLOSE : wsdf_pkg::KIND_PING;
                res_last  = 1'b1;
            end else if (len_val == 64'd0) begin
                n_phase   = wsdf_pkg::PH_HDR0;
                res_valid = 1'b1;
                res_kind  = wsdf_pkg::KIND_EMPTY;
                res_text  = (r_opcode == wsdf_pkg::OP_TEXT);
                res_last  = 1'b1;
            end else begin
                n_phase     = wsdf_pkg::PH_DATA;
                n_delivered = 16'd0;
                n_key_idx   = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= wsdf_pkg::LIMIT_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= wsdf_pkg::PH_HDR0;
            r_opcode    <= 4'd0;
            r_mask_on   <= 1'b0;
            r_rem       <= 64'd0;
            r_ext_cnt   <= 3'd0;
            r_key_idx   <= 2'd0;
            r_delivered <= 16'd0;
        end else begin
            if (i_cfg_we)
                r_limit <= i_cfg_wdata;
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (advance)
                r_out_valid <= step && res_valid;
            if (step) begin
                r_phase     <= n_phase;
                r_opcode    <= n_opcode;
                r_mask_on   <= n_mask_on;
                r_rem       <= n_rem;
                r_ext_cnt   <= n_ext_cnt;
                r_key_idx   <= n_key_idx;
                r_delivered <= n_delivered;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid)
            r_in_byte <= s_axis_tdata;
        if (step) begin
            r_key <= n_key;
        end
        if (step && res_valid) begin
            r_out_data  <= res_data;
            r_out_kind  <= res_kind;
            r_out_text  <= res_text;
            r_out_last  <= res_last;
            r_out_trunc <= res_trunc;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = {r_out_trunc, r_out_text, r_out_kind};
    assign m_axis_tlast  = r_out_last;

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == wsdf_pkg::PH_DATA || r_phase == wsdf_pkg::PH_SKIP) |-> r_rem != 64'd0)
        else $error("payload phase with no bytes left");

    a_ctrl_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[2]
                                               && !m_axis_tuser[3]))
        else $error("control event without last or with data flags");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[3]) |-> (m_axis_tlast
                                               && m_axis_tuser[1:0] == wsdf_pkg::KIND_DATA))
        else $error("truncation flag outside last payload byte");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid || !r_out_valid) |-> s_axis_tready)
        else $error("input stalled with a free register");

endmodule
